// ----- rtl/core/kpl_pkg.sv -----
// ----------------------------------------------------------------------------
// kpl_pkg: shared types and codes for the keypad passcode lock.
// Holds key codes, mode codes, event codes and the result record.
// ----------------------------------------------------------------------------
package kpl_pkg;

    typedef logic [3:0]  key_t;
    typedef logic [2:0]  mode_t;
    typedef logic [2:0]  event_t;
    typedef logic [10:0] duty_t;
    typedef logic [0:0]  cfg_index_t;

    typedef struct packed {
        mode_t  mode;
        event_t event_res;
        logic   bolt_open;
        logic   led_level;
        duty_t  servo_duty;
    } result_t;

    localparam key_t KEY_DIGIT_MAX = 4'd9;
    localparam key_t KEY_A         = 4'd10;
    localparam key_t KEY_B         = 4'd11;
    localparam key_t KEY_C         = 4'd12;
    localparam key_t KEY_D         = 4'd13;

    localparam mode_t M_IDLE       = 3'd0;
    localparam mode_t M_OPEN_ENTRY = 3'd1;
    localparam mode_t M_UNLOCKED   = 3'd2;
    localparam mode_t M_VERIFY_OLD = 3'd3;
    localparam mode_t M_NEW_ENTRY  = 3'd4;
    localparam mode_t M_CONFIRM    = 3'd5;

    localparam event_t EV_NONE     = 3'd0;
    localparam event_t EV_DIGIT    = 3'd1;
    localparam event_t EV_GRANTED  = 3'd2;
    localparam event_t EV_WRONG    = 3'd3;
    localparam event_t EV_LOCKED   = 3'd4;
    localparam event_t EV_CHANGED  = 3'd5;
    localparam event_t EV_MISMATCH = 3'd6;
    localparam event_t EV_STARTED  = 3'd7;

    localparam cfg_index_t CFG_OPEN_DUTY   = 1'd0;
    localparam cfg_index_t CFG_CLOSED_DUTY = 1'd1;

    localparam duty_t OPEN_DUTY_RESET   = 11'd250;
    localparam duty_t CLOSED_DUTY_RESET = 11'd50;

    localparam int RESET_CODE = 1111;

endpackage

// ----- rtl/core/kpl_if.sv -----
// ----------------------------------------------------------------------------
// kpl_if: item channels of the keypad passcode lock.
// One channel carries key presses in, the other carries results out.
// ----------------------------------------------------------------------------
interface kpl_key_if;
    logic          valid;
    logic          ready;
    kpl_pkg::key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface kpl_res_if;
    logic              valid;
    logic              ready;
    kpl_pkg::mode_t    mode;
    kpl_pkg::event_t   event_res;
    logic              bolt_open;
    logic              led_level;
    kpl_pkg::duty_t    servo_duty;

    modport source (output valid, output mode, output event_res, output bolt_open,
                    output led_level, output servo_duty, input ready);
    modport sink   (input valid, input mode, input event_res, input bolt_open,
                    input led_level, input servo_duty, output ready);
endinterface

// ----- rtl/core/kpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpl_ctrl: lock state machine and code accumulators.
// Updates the lock state for each accepted item and forms its result.
// ----------------------------------------------------------------------------
module kpl_ctrl #(
    parameter int CODE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  kpl_pkg::key_t       key,
    input  logic                cfg_wen,
    input  kpl_pkg::cfg_index_t cfg_index,
    input  kpl_pkg::duty_t      cfg_data,
    output kpl_pkg::result_t    res
);

    localparam logic [CODE_WIDTH-1:0] CODE_ONE   = CODE_WIDTH'(1);
    localparam logic [CODE_WIDTH-1:0] CODE_RESET = CODE_WIDTH'(kpl_pkg::RESET_CODE);

    kpl_pkg::mode_t        mode_reg, mode_next;
    logic [CODE_WIDTH-1:0] entry_reg, entry_next;
    logic [CODE_WIDTH-1:0] new_code_reg, new_code_next;
    logic [CODE_WIDTH-1:0] stored_reg, stored_next;
    logic                  bolt_reg, bolt_next;
    logic                  led_reg, led_next;
    kpl_pkg::duty_t        open_duty_reg, closed_duty_reg;
    kpl_pkg::event_t       ev;
    logic                  digit;
    logic [CODE_WIDTH-1:0] key_ext;
    logic [CODE_WIDTH-1:0] entry_push;
    logic [CODE_WIDTH-1:0] new_push;

    assign digit      = (key <= kpl_pkg::KEY_DIGIT_MAX);
    assign key_ext    = CODE_WIDTH'(key);
    assign entry_push = (entry_reg << 3) + (entry_reg << 1) + key_ext;
    assign new_push   = (new_code_reg << 3) + (new_code_reg << 1) + key_ext;

    always_comb
    begin
        mode_next     = mode_reg;
        entry_next    = entry_reg;
        new_code_next = new_code_reg;
        stored_next   = stored_reg;
        bolt_next     = bolt_reg;
        led_next      = led_reg;
        ev            = kpl_pkg::EV_NONE;
        unique case (mode_reg) inside
            kpl_pkg::M_OPEN_ENTRY, kpl_pkg::M_VERIFY_OLD:
            begin
                if (digit)
                begin
                    entry_next = entry_push;
                    ev         = kpl_pkg::EV_DIGIT;
                end
                else if (key == kpl_pkg::KEY_D)
                begin
                    entry_next = CODE_ONE;
                    ev         = kpl_pkg::EV_GRANTED;
                    if (entry_reg != stored_reg)
                    begin
                        mode_next = kpl_pkg::M_IDLE;
                        ev        = kpl_pkg::EV_WRONG;
                    end
                    else if (mode_reg == kpl_pkg::M_OPEN_ENTRY)
                    begin
                        bolt_next = 1'b1;
                        led_next  = 1'b0;
                        mode_next = kpl_pkg::M_UNLOCKED;
                    end
                    else
                    begin
                        new_code_next = CODE_ONE;
                        mode_next     = kpl_pkg::M_NEW_ENTRY;
                    end
                end
            end
            kpl_pkg::M_UNLOCKED:
            begin
                if (key == kpl_pkg::KEY_C)
                begin
                    bolt_next = 1'b0;
                    led_next  = 1'b1;
                    mode_next = kpl_pkg::M_IDLE;
                    ev        = kpl_pkg::EV_LOCKED;
                end
            end
            kpl_pkg::M_NEW_ENTRY:
            begin
                if (digit)
                begin
                    new_code_next = new_push;
                    ev            = kpl_pkg::EV_DIGIT;
                end
                else if (key == kpl_pkg::KEY_D)
                begin
                    entry_next = CODE_ONE;
                    mode_next  = kpl_pkg::M_CONFIRM;
                    ev         = kpl_pkg::EV_STARTED;
                end
            end
            kpl_pkg::M_CONFIRM:
            begin
                if (digit)
                begin
                    entry_next = entry_push;
                    ev         = kpl_pkg::EV_DIGIT;
                end
                else if (key == kpl_pkg::KEY_D)
                begin
                    if (entry_reg == new_code_reg)
                    begin
                        stored_next = new_code_reg;
                        ev          = kpl_pkg::EV_CHANGED;
                    end
                    else
                    begin
                        ev = kpl_pkg::EV_MISMATCH;
                    end
                    entry_next = CODE_ONE;
                    mode_next  = kpl_pkg::M_IDLE;
                end
            end
            default:
            begin
                mode_next = kpl_pkg::M_IDLE;
                if (key == kpl_pkg::KEY_A)
                begin
                    entry_next = CODE_ONE;
                    mode_next  = kpl_pkg::M_OPEN_ENTRY;
                    ev         = kpl_pkg::EV_STARTED;
                end
                else if (key == kpl_pkg::KEY_B)
                begin
                    entry_next = CODE_ONE;
                    mode_next  = kpl_pkg::M_VERIFY_OLD;
                    ev         = kpl_pkg::EV_STARTED;
                end
                else if (key == kpl_pkg::KEY_C)
                begin
                    bolt_next = 1'b0;
                    led_next  = 1'b1;
                    ev        = kpl_pkg::EV_LOCKED;
                end
            end
        endcase
    end

    always_comb
    begin
        res.mode       = mode_next;
        res.event_res  = ev;
        res.bolt_open  = bolt_next;
        res.led_level  = led_next;
        res.servo_duty = bolt_next ? open_duty_reg : closed_duty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= kpl_pkg::M_IDLE;
            entry_reg    <= CODE_ONE;
            new_code_reg <= CODE_ONE;
            stored_reg   <= CODE_RESET;
            bolt_reg     <= 1'b0;
            led_reg      <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            entry_reg    <= entry_next;
            new_code_reg <= new_code_next;
            stored_reg   <= stored_next;
            bolt_reg     <= bolt_next;
            led_reg      <= led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_duty_reg   <= kpl_pkg::OPEN_DUTY_RESET;
            closed_duty_reg <= kpl_pkg::CLOSED_DUTY_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                kpl_pkg::CFG_OPEN_DUTY:   open_duty_reg   <= cfg_data;
                kpl_pkg::CFG_CLOSED_DUTY: closed_duty_reg <= cfg_data;
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // The LED pin is always the inverse of the bolt.
    a_led_tracks_bolt: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg == !bolt_reg)
        else $error("LED level does not mirror bolt state");

    // The bolt is open exactly while the lock sits in the unlocked mode.
    a_bolt_only_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == kpl_pkg::M_UNLOCKED) == bolt_reg)
        else $error("bolt state disagrees with lock mode");

    // The stored code only changes on a confirmed code change.
    a_code_change: assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg != $past(stored_reg)) |->
            ($past(accept) && $past(ev) == kpl_pkg::EV_CHANGED))
        else $error("stored code changed without confirmation");
`endif

endmodule

// ----- rtl/core/kpl_out_buf.sv -----
// ----------------------------------------------------------------------------
// kpl_out_buf: result register with a skid stage.
// Holds finished results so that a new item is taken while the sink stalls.
// ----------------------------------------------------------------------------
module kpl_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  kpl_pkg::result_t push_data,
    kpl_res_if.source        result
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    kpl_pkg::result_t out_data_reg, out_data_next;
    kpl_pkg::result_t skid_data_reg, skid_data_next;

    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push_valid;
                out_data_next  = push_data;
            end
        end
        else if (push_valid && push_ready)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.mode       = out_data_reg.mode;
    assign result.event_res  = out_data_reg.event_res;
    assign result.bolt_open  = out_data_reg.bolt_open;
    assign result.led_level  = out_data_reg.led_level;
    assign result.servo_duty = out_data_reg.servo_duty;

`ifndef SYNTH
    // The skid stage only fills behind a held output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output is empty");

    // The skid stage fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid stage filled without an output stall");
`endif

endmodule

// ----- rtl/core/keypad_passcode_lock_top.sv -----
// ----------------------------------------------------------------------------
// keypad_passcode_lock_top: keypad passcode lock controller.
// The result of an item is registered in the output buffer, or in its skid stage while the sink stalls.
// Throughput: one item per cycle while the result buffer has room; the lock state updates in the accept cycle.
// A two-entry result buffer lets one item in while the sink stalls.
// Reset clears to idle, closed bolt, stored code 1111 and default duties.
// ----------------------------------------------------------------------------
module keypad_passcode_lock_top #(
    parameter int CODE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  kpl_pkg::cfg_index_t cfg_index,
    input  kpl_pkg::duty_t      cfg_data,
    kpl_key_if.sink             press,
    kpl_res_if.source           result
);

    logic             accept;
    logic             push_ready;
    kpl_pkg::result_t step_res;

    assign press.ready = push_ready;
    assign accept      = press.valid && push_ready;

    kpl_ctrl #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .key       (press.key),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (step_res)
    );

    kpl_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (press.valid),
        .push_ready (push_ready),
        .push_data  (step_res),
        .result     (result)
    );

endmodule
